[rtl/utf16_to_utf8_transcoder_core_macros.svh]
// assertion macros for the transcoder rtl
// expects signals named clock and reset in the module that uses them
`ifndef UTF16_TO_UTF8_TRANSCODER_CORE_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define U16U8_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("u16u8 assertion failed");
`define U16U8_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("u16u8 forbidden condition seen");
`else
`define U16U8_ASSERT(label, prop)
`define U16U8_NEVER(label, cond)
`endif
`endif

[rtl/u16u8_pkg.sv]
// shared types and constants of the utf-16 to utf-8 transcoder
// no dependencies
package u16u8_pkg;

   localparam logic [15:0] SURR_MASK = 16'hfc00;
   localparam logic [15:0] HIGH_SURR = 16'hd800;
   localparam logic [15:0] LOW_SURR  = 16'hdc00;
   localparam logic [20:0] SUPP_BASE = 21'h10000;
   localparam logic [15:0] CP_TWO_BYTES   = 16'h0080;
   localparam logic [15:0] CP_THREE_BYTES = 16'h0800;

   localparam int QUEUE_DEPTH_DEF = 2;

   // utf-8 sequence length
   typedef enum logic [1:0] {
      LEN_1 = 2'd0,
      LEN_2 = 2'd1,
      LEN_3 = 2'd2,
      LEN_4 = 2'd3
   } len_type;

   // one classified unit of work for the back end
   typedef struct packed {
      logic        bad;
      len_type     len;
      logic [20:0] cp;
   } cmd_type;

   // front to queue
   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

endpackage

[rtl/u16u8_front.sv]
// front end: surrogate tracking and classification of code units
// depends on u16u8_pkg
module u16u8_front
   import u16u8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [15:0] code_unit,
   output push_type    to_queue
);

   logic       pending_ff, pending_in;
   logic [9:0] high_ff, high_in;
   logic       is_high, is_low;
   cmd_type    cmd;

   assign is_high = (code_unit & SURR_MASK) == HIGH_SURR;
   assign is_low  = (code_unit & SURR_MASK) == LOW_SURR;

   always_comb begin
      pending_in = pending_ff;
      high_in    = high_ff;
      cmd.bad    = 1'b0;
      cmd.len    = LEN_1;
      cmd.cp     = {5'd0, code_unit};
      if (pending_ff) begin
         if (is_low) begin
            cmd.len = LEN_4;
            cmd.cp  = SUPP_BASE + {1'b0, high_ff, code_unit[9:0]};
         end else begin
            cmd.bad = 1'b1;
         end
      end else if (is_low) begin
         cmd.bad = 1'b1;
      end else if (code_unit >= CP_THREE_BYTES) begin
         cmd.len = LEN_3;
      end else if (code_unit >= CP_TWO_BYTES) begin
         cmd.len = LEN_2;
      end
      if (accept) begin
         pending_in = !pending_ff && is_high;
         high_in    = (!pending_ff && is_high) ? code_unit[9:0] : 10'd0;
      end
   end

   // a fresh high surrogate is only held
   assign to_queue.push = accept && (pending_ff || !is_high);
   assign to_queue.cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         high_ff    <= 10'd0;
      end else begin
         pending_ff <= pending_in;
         high_ff    <= high_in;
      end
   end

endmodule

[rtl/u16u8_queue.sv]
// small command queue between front and back end
// depends on u16u8_pkg
module u16u8_queue
   import u16u8_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type wr,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output cmd_type  head
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   cmd_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = count_ff == FULL_CNT;
   assign valid   = count_ff != '0;
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = wr.push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/u16u8_back.sv]
// back end: byte sequencer with output register
// depends on u16u8_pkg
module u16u8_back
   import u16u8_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  cmd_type    q_head,
   output logic       q_pop,
   output logic       out_valid,
   input  logic       out_pop,
   output logic [7:0] out_byte,
   output logic       end_of_name,
   output logic       bad_sequence,
   output logic       last_of_run
);

   logic       cur_valid_ff, cur_valid_in;
   cmd_type    cur_ff;
   logic [1:0] idx_ff, idx_in;
   logic       ov_ff, ov_in;
   logic [7:0] byte_ff, byte_in;
   logic       eon_ff, bad_ff, last_ff;
   logic       adv, cur_last, load;
   logic [1:0] rem;
   logic [5:0] seg;
   logic [7:0] lead;

   assign adv      = cur_valid_ff && (!ov_ff || out_pop);
   assign cur_last = cur_ff.bad || (idx_ff == cur_ff.len);
   assign load     = q_valid && (!cur_valid_ff || (adv && cur_last));
   assign q_pop    = load;
   assign rem      = cur_ff.len - idx_ff;

   always_comb begin
      unique case (rem)
         2'd0:    seg = cur_ff.cp[5:0];
         2'd1:    seg = cur_ff.cp[11:6];
         2'd2:    seg = cur_ff.cp[17:12];
         default: seg = {3'b000, cur_ff.cp[20:18]};
      endcase
      unique case (cur_ff.len)
         LEN_1: lead = {1'b0, cur_ff.cp[6:0]};
         LEN_2: lead = {3'b110, cur_ff.cp[10:6]};
         LEN_3: lead = {4'b1110, cur_ff.cp[15:12]};
         LEN_4: lead = {5'b11110, cur_ff.cp[20:18]};
         default: lead = 8'd0;
      endcase
      if (cur_ff.bad) begin
         byte_in = 8'd0;
      end else if (idx_ff == 2'd0) begin
         byte_in = lead;
      end else begin
         byte_in = {2'b10, seg};
      end
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      ov_in        = ov_ff;
      if (load) begin
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (adv && cur_last) begin
         cur_valid_in = 1'b0;
      end else if (adv) begin
         idx_in = idx_ff + 1'b1;
      end
      if (adv) begin
         ov_in = 1'b1;
      end else if (out_pop) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_head;
      end
      if (adv) begin
         byte_ff <= byte_in;
         eon_ff  <= !cur_ff.bad && (cur_ff.len == LEN_1) && (cur_ff.cp[6:0] == 7'd0);
         bad_ff  <= cur_ff.bad;
         last_ff <= cur_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         ov_ff        <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         ov_ff        <= ov_in;
      end
   end

   assign out_valid    = ov_ff;
   assign out_byte     = byte_ff;
   assign end_of_name  = eon_ff;
   assign bad_sequence = bad_ff;
   assign last_of_run  = last_ff;

endmodule

[rtl/utf16_to_utf8_transcoder_core.sv]
// top level of the utf-16 to utf-8 transcoder
// depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back and the macros header
//
// Streams utf-16 code units in and utf-8 bytes out, one byte per beat, lead
// byte first. The bytes of a code unit leave at one per cycle while results
// are popped; a unit has 1 to 3 bytes, 4 for a surrogate pair and 0 for a
// held high surrogate.
// The output byte sequencer is the bottleneck: unstalled throughput is one
// byte per clock. A zero unit yields byte 0 with end_of_name set. A lone low
// surrogate, or a held high surrogate followed by anything but a low one,
// yields one beat with bad_sequence set and out_byte 0; in the latter case the
// following unit is swallowed and the held surrogate is dropped.
// last_of_run marks the final beat produced by one input unit. Input and
// result channels are independent; a short command queue lets input keep
// flowing while results stall, up to QUEUE_DEPTH commands plus two in flight.
`include "utf16_to_utf8_transcoder_core_macros.svh"
module utf16_to_utf8_transcoder_core
   import u16u8_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_code_unit,
   // result channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_name,
   output logic        rsp_bad_sequence,
   output logic        rsp_last_of_run
);

   push_type to_queue;
   cmd_type  q_head;
   logic     q_full, q_valid, q_pop;
   logic     accept;
   logic     out_valid;

   // the input is stalled only when the command queue is full
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // classification and surrogate pairing
   u16u8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .code_unit (req_code_unit),
      .to_queue  (to_queue)
   );

   // decouples input rate from byte output rate
   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (to_queue),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .head  (q_head)
   );

   // byte sequencer and output register
   u16u8_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .out_valid    (out_valid),
      .out_pop      (rsp_pop),
      .out_byte     (rsp_out_byte),
      .end_of_name  (rsp_end_of_name),
      .bad_sequence (rsp_bad_sequence),
      .last_of_run  (rsp_last_of_run)
   );

   assign rsp_empty = !out_valid;

   // error beats carry a zero byte and close their run
   `U16U8_ASSERT(a_bad_beat, !rsp_empty && rsp_bad_sequence |-> rsp_out_byte == 8'd0 && rsp_last_of_run)
   // terminator is a lone zero byte, never flagged bad
   `U16U8_ASSERT(a_eon_beat, !rsp_empty && rsp_end_of_name |-> rsp_out_byte == 8'd0 && rsp_last_of_run && !rsp_bad_sequence)
   // every beat that is not the last of its run belongs to a multi-byte sequence
   `U16U8_NEVER(a_mid_ascii, !rsp_empty && !rsp_last_of_run && !rsp_out_byte[7])

endmodule
